FILE: rtl/nerc_pkg.sv
package nerc_pkg;

   // field widths
   localparam int LABEL_BITS  = 16;
   localparam int TAG_BITS    = 16;
   localparam int ENABLE_BITS = 7;

   // node queue between classifier and net tracker
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   // node kinds
   localparam logic [2:0] KIND_POWER  = 3'd2;
   localparam logic [2:0] KIND_MARKER = 3'd3;
   localparam logic [2:0] KIND_PIN    = 3'd4;

   // pin electrical types
   localparam logic [2:0] ELEC_IN      = 3'd0;
   localparam logic [2:0] ELEC_OUT     = 3'd1;
   localparam logic [2:0] ELEC_TRI     = 3'd2;
   localparam logic [2:0] ELEC_OC      = 3'd3;
   localparam logic [2:0] ELEC_PASSIVE = 3'd4;
   localparam logic [2:0] ELEC_BIDIR   = 3'd5;
   localparam logic [2:0] ELEC_NC      = 3'd6;

   // node types
   localparam logic [2:0] NODE_UNKNOWN   = 3'd0;
   localparam logic [2:0] NODE_PASSIVE   = 3'd1;
   localparam logic [2:0] NODE_INPUT     = 3'd2;
   localparam logic [2:0] NODE_OUTPUT    = 3'd3;
   localparam logic [2:0] NODE_BIDIR     = 3'd4;
   localparam logic [2:0] NODE_POWER     = 3'd5;
   localparam logic [2:0] NODE_NOCONNECT = 3'd6;

   // net types, locked error codes sit above NET_ERR_BASE
   localparam logic [3:0] NET_UNKNOWN   = 4'd0;
   localparam logic [3:0] NET_PASSIVE   = 4'd1;
   localparam logic [3:0] NET_INPUT     = 4'd2;
   localparam logic [3:0] NET_OUTPUT    = 4'd3;
   localparam logic [3:0] NET_BIDIR     = 4'd4;
   localparam logic [3:0] NET_POWER     = 4'd5;
   localparam logic [3:0] NET_NOCONNECT = 4'd6;
   localparam logic [3:0] NET_ERR_BASE  = 4'd6;
   localparam logic [3:0] NET_LOCK_MIN  = 4'd7;

   localparam logic [1:0] LINK_MAX = 2'd3;

   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_SINGLE_LINK = 4'd1,
      ERR_POWER_CLASH = 4'd2,
      ERR_NC_CONFLICT = 4'd3,
      ERR_NO_DRIVER   = 4'd4,
      ERR_OUTPUTS     = 4'd5,
      ERR_OUT_POWER   = 4'd6,
      ERR_STRAY       = 4'd7,
      ERR_OUT_BIDIR   = 4'd8,
      ERR_POWER_BIDIR = 4'd9
   } err_code_type;

   typedef struct packed {
      logic [2:0]            node_kind;
      logic [2:0]            pin_elec;
      logic                  pin_is_power;
      logic [LABEL_BITS-1:0] power_label;
      logic [TAG_BITS-1:0]   node_tag;
      logic                  last_of_net;
   } req_type;

   typedef struct packed {
      err_code_type        error_code;
      logic [TAG_BITS-1:0] locator_tag;
   } rsp_type;

   // classified node as it travels through the queue
   typedef struct packed {
      logic                  is_power_sym;
      logic                  counts_link;
      logic                  takes_tag;
      logic [2:0]            node_type;
      logic [LABEL_BITS-1:0] label;
      logic [TAG_BITS-1:0]   tag;
      logic                  last;
   } node_class_type;

   function automatic logic [3:0] lock_of(input err_code_type code);
      return NET_ERR_BASE + code;
   endfunction

   function automatic logic [2:0] pin_type(input logic [2:0] elec, input logic is_power);
      logic [2:0] res;
      res = NODE_UNKNOWN;
      if (is_power) begin
         res = NODE_POWER;
      end else begin
         unique case (elec)
            ELEC_IN:      res = NODE_INPUT;
            ELEC_OUT:     res = NODE_OUTPUT;
            ELEC_TRI:     res = NODE_BIDIR;
            ELEC_OC:      res = NODE_BIDIR;
            ELEC_PASSIVE: res = NODE_PASSIVE;
            ELEC_BIDIR:   res = NODE_BIDIR;
            ELEC_NC:      res = NODE_NOCONNECT;
            default:      res = NODE_UNKNOWN;
         endcase
      end
      return res;
   endfunction

   // 7x7 net type step, net type against node type
   function automatic logic [3:0] net_step(input logic [3:0] kind, input logic [2:0] nt);
      logic [3:0] res;
      res = kind;
      unique case (kind)
         NET_UNKNOWN: begin
            res = {1'b0, nt};
         end
         NET_PASSIVE, NET_INPUT: begin
            unique case (nt)
               NODE_PASSIVE:   res = NET_PASSIVE;
               NODE_OUTPUT:    res = NET_OUTPUT;
               NODE_BIDIR:     res = NET_BIDIR;
               NODE_POWER:     res = NET_POWER;
               NODE_NOCONNECT: res = lock_of(ERR_NC_CONFLICT);
               default:        res = kind;
            endcase
         end
         NET_OUTPUT: begin
            unique case (nt)
               NODE_OUTPUT:    res = lock_of(ERR_OUTPUTS);
               NODE_BIDIR:     res = lock_of(ERR_OUT_BIDIR);
               NODE_POWER:     res = lock_of(ERR_POWER_BIDIR);
               NODE_NOCONNECT: res = lock_of(ERR_NC_CONFLICT);
               default:        res = kind;
            endcase
         end
         NET_BIDIR: begin
            unique case (nt)
               NODE_OUTPUT:    res = lock_of(ERR_OUT_BIDIR);
               NODE_POWER:     res = lock_of(ERR_POWER_BIDIR);
               NODE_NOCONNECT: res = lock_of(ERR_NC_CONFLICT);
               default:        res = kind;
            endcase
         end
         NET_POWER: begin
            unique case (nt)
               NODE_OUTPUT:    res = lock_of(ERR_OUT_POWER);
               NODE_BIDIR:     res = lock_of(ERR_POWER_BIDIR);
               NODE_NOCONNECT: res = lock_of(ERR_NC_CONFLICT);
               default:        res = kind;
            endcase
         end
         NET_NOCONNECT: begin
            res = (nt == NODE_UNKNOWN) ? kind : lock_of(ERR_NC_CONFLICT);
         end
         default: begin
            res = kind;
         end
      endcase
      return res;
   endfunction

   function automatic logic code_enabled(input err_code_type code,
                                         input logic [ENABLE_BITS-1:0] en);
      logic res;
      res = 1'b0;
      unique case (code)
         ERR_SINGLE_LINK:                 res = en[0];
         ERR_POWER_CLASH:                 res = en[1];
         ERR_NC_CONFLICT:                 res = en[2];
         ERR_NO_DRIVER:                   res = en[3];
         ERR_OUTPUTS, ERR_OUT_BIDIR:      res = en[4];
         ERR_OUT_POWER, ERR_POWER_BIDIR:  res = en[5];
         ERR_STRAY:                       res = en[6];
         default:                         res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/nerc_front.sv
module nerc_front
   import nerc_pkg::*;
(
   input  logic           req_valid,
   input  req_type        req_data,
   input  logic           q_full,
   output logic           req_ready,
   output logic           push,
   output node_class_type cls
);

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   // decode one node into what the net tracker needs
   always_comb begin
      cls              = '0;
      cls.label        = req_data.power_label;
      cls.tag          = req_data.node_tag;
      cls.last         = req_data.last_of_net;
      unique case (req_data.node_kind)
         KIND_POWER: begin
            cls.is_power_sym = 1'b1;
            cls.takes_tag    = 1'b1;
            cls.node_type    = NODE_POWER;
         end
         KIND_MARKER: begin
            cls.counts_link  = 1'b1;
            cls.takes_tag    = 1'b1;
            cls.node_type    = NODE_PASSIVE;
         end
         KIND_PIN: begin
            cls.counts_link  = 1'b1;
            cls.takes_tag    = 1'b1;
            cls.node_type    = pin_type(req_data.pin_elec, req_data.pin_is_power);
         end
         default: begin
            cls.node_type    = NODE_UNKNOWN;
         end
      endcase
   end

endmodule

FILE: rtl/nerc_queue.sv
module nerc_queue
   import nerc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  node_class_type push_data,
   input  logic           pop,
   output logic           pop_valid,
   output node_class_type pop_data,
   output logic           full
);

   node_class_type          entries_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]   count_ff, count_in;

   function automatic logic [Q_PTR_BITS-1:0] ptr_next(input logic [Q_PTR_BITS-1:0] p);
      return (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/nerc_back.sv
module nerc_back
   import nerc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ENABLE_BITS-1:0] error_enable,
   input  logic                   q_valid,
   input  node_class_type         q_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);

   logic [3:0]            net_kind_ff, net_kind_in, kind_upd, kind_now;
   logic [1:0]            link_count_ff, link_count_in, link_upd;
   logic                  label_seen_ff, label_seen_in, seen_upd;
   logic [LABEL_BITS-1:0] first_label_ff, first_label_in, label_upd;
   logic [TAG_BITS-1:0]   held_tag_ff, held_tag_in, tag_upd;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  locked, clash, finish;
   err_code_type          code;

   assign pop    = q_valid && (!q_data.last || !rsp_valid_ff || rsp_ready);
   assign finish = pop && q_data.last;

   // per-node update of the net state
   always_comb begin
      locked    = (net_kind_ff >= NET_LOCK_MIN);
      clash     = q_data.is_power_sym && label_seen_ff && (first_label_ff != q_data.label);
      kind_upd  = net_kind_ff;
      link_upd  = link_count_ff;
      seen_upd  = label_seen_ff;
      label_upd = first_label_ff;
      tag_upd   = held_tag_ff;
      if (!locked) begin
         if (q_data.takes_tag) begin
            tag_upd = q_data.tag;
         end
         if (q_data.is_power_sym && !label_seen_ff) begin
            seen_upd  = 1'b1;
            label_upd = q_data.label;
         end
         if (q_data.counts_link && link_count_ff != LINK_MAX) begin
            link_upd = link_count_ff + 1'b1;
         end
         kind_upd = clash ? lock_of(ERR_POWER_CLASH) : net_step(net_kind_ff, q_data.node_type);
      end
   end

   // end-of-net rules
   always_comb begin
      kind_now = kind_upd;
      if (link_upd == 2'd1 && kind_upd != NET_NOCONNECT) begin
         kind_now = lock_of(ERR_SINGLE_LINK);
      end
      if (kind_now >= NET_LOCK_MIN) begin
         code = err_code_type'(kind_now - NET_ERR_BASE);
      end else if (kind_now == NET_UNKNOWN) begin
         code = (link_upd != 2'd0) ? ERR_STRAY : ERR_NONE;
      end else if (kind_now == NET_INPUT) begin
         code = ERR_NO_DRIVER;
      end else begin
         code = ERR_NONE;
      end
      if (!code_enabled(code, error_enable)) begin
         code = ERR_NONE;
      end
   end

   always_comb begin
      net_kind_in    = q_data.last ? NET_UNKNOWN : kind_upd;
      link_count_in  = q_data.last ? 2'd0 : link_upd;
      label_seen_in  = q_data.last ? 1'b0 : seen_upd;
      first_label_in = q_data.last ? '0 : label_upd;
      held_tag_in    = q_data.last ? '0 : tag_upd;
      rsp_data_in.error_code  = code;
      rsp_data_in.locator_tag = tag_upd;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         net_kind_ff    <= NET_UNKNOWN;
         link_count_ff  <= '0;
         label_seen_ff  <= 1'b0;
         first_label_ff <= '0;
         held_tag_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            net_kind_ff    <= net_kind_in;
            link_count_ff  <= link_count_in;
            label_seen_ff  <= label_seen_in;
            first_label_ff <= first_label_in;
            held_tag_ff    <= held_tag_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/net_electrical_rule_classifier_core.sv
// Net electrical rule classifier. Nodes of a net arrive one request per node, the
// last one flagged by last_of_net; each finished net yields one response with the
// error code (0 when clean or when that error's enable bit is off) and the tag of the
// last power, marker or pin node taken before the net locked. Requests are taken one
// per cycle for as long as the response side keeps up: the node classifier feeds a
// four-entry queue and the net tracker drains one node per cycle into the response
// register, so rsp_valid is registered and rises once the tracker takes the node ending its net.
// Only a stalled response holds the tracker, and only once the node at the head of
// the queue ends a net; the queue then holds that node and up to three more before
// req_ready drops. The error enable register resets to all ones and should be
// written only while no net is in flight.
module net_electrical_rule_classifier_core
   import nerc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // node requests
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   // per-net responses
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   // error enable register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ENABLE_BITS-1:0] csr_data
);

   logic [ENABLE_BITS-1:0] error_enable_ff, error_enable_in;
   logic                   q_full, push, pop, q_valid;
   node_class_type         cls, q_data;

   // enable register, always writable
   assign csr_ready       = 1'b1;
   assign error_enable_in = (csr_valid && csr_ready) ? csr_data : error_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_enable_ff <= '1;
      end else begin
         error_enable_ff <= error_enable_in;
      end
   end

   // front: decode each node kind and pin type
   nerc_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_ready (req_ready),
      .push      (push),
      .cls       (cls)
   );

   // decoupling queue
   nerc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cls),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .full      (q_full)
   );

   // back: net type tracking, end-of-net rules, response register
   nerc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .error_enable (error_enable_ff),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

FILE: rtl/nerc_checker.sv
module nerc_checker
   import nerc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // no response straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // error codes stay within the defined set
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.error_code <= ERR_POWER_BIDIR))
      else $error("error code out of range");

   // the queue can only fill up behind a stalled response
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled while response side idle");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind net_electrical_rule_classifier_core nerc_checker u_nerc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/net_electrical_rule_classifier_core_tb.sv
module net_electrical_rule_classifier_core_tb;
   import nerc_pkg::*;

   // node kinds and pin types the package leaves unnamed
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_OTHER = 3'd1;
   localparam logic [2:0] ELEC_UNDEF = 3'd7;

   localparam logic [ENABLE_BITS-1:0] ENABLE_ALL  = '1;
   localparam logic [ENABLE_BITS-1:0] ENABLE_NONE = '0;

   // queue depth plus the response register, with margin
   localparam int DRAIN_CYCLES = 12;
   localparam int LIMIT_CYCLES = 400000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [ENABLE_BITS-1:0] csr_data;

   // net classification model, same reset values as the block
   logic [ENABLE_BITS-1:0] enable_bits = ENABLE_ALL;
   logic [3:0]             net_state   = NET_UNKNOWN;
   logic [1:0]             links       = 2'd0;
   logic                   label_seen  = 1'b0;
   logic [LABEL_BITS-1:0]  first_label = '0;
   logic [TAG_BITS-1:0]    held_tag    = '0;

   rsp_type net_results[$];   // verdicts of finished nets, oldest first

   int fail_count   = 0;
   int nodes_sent   = 0;      // counts requests other than KIND_NONE
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold_req = 0;      // long response stall, picked up by the receiver

   net_electrical_rule_classifier_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // net type step from current net type and node type
   function automatic logic [3:0] next_net(input logic [3:0] cur, input logic [2:0] nt);
      logic [3:0] res;
      res = cur;
      if (cur == NET_UNKNOWN) begin
         res = {1'b0, nt};
      end else if (nt == NODE_UNKNOWN) begin
         res = cur;
      end else if (cur == NET_NOCONNECT || nt == NODE_NOCONNECT) begin
         res = NET_ERR_BASE + ERR_NC_CONFLICT;
      end else begin
         case (cur)
            NET_PASSIVE, NET_INPUT: begin
               // an input never outranks passive, anything stronger takes over
               res = (nt == NODE_INPUT) ? cur : {1'b0, nt};
            end
            NET_OUTPUT: begin
               case (nt)
                  NODE_OUTPUT: res = NET_ERR_BASE + ERR_OUTPUTS;
                  NODE_BIDIR:  res = NET_ERR_BASE + ERR_OUT_BIDIR;
                  NODE_POWER:  res = NET_ERR_BASE + ERR_POWER_BIDIR;
                  default:     res = cur;
               endcase
            end
            NET_BIDIR: begin
               case (nt)
                  NODE_OUTPUT: res = NET_ERR_BASE + ERR_OUT_BIDIR;
                  NODE_POWER:  res = NET_ERR_BASE + ERR_POWER_BIDIR;
                  default:     res = cur;
               endcase
            end
            NET_POWER: begin
               case (nt)
                  NODE_OUTPUT: res = NET_ERR_BASE + ERR_OUT_POWER;
                  NODE_BIDIR:  res = NET_ERR_BASE + ERR_POWER_BIDIR;
                  default:     res = cur;
               endcase
            end
            default: begin
               res = cur;
            end
         endcase
      end
      return res;
   endfunction

   // fold one accepted node into the net, queue a verdict when the net ends
   task automatic classify_node(input req_type n);
      logic [2:0]   nt;
      logic [3:0]   verdict;
      logic         on;
      err_code_type code;
      rsp_type      r;
      nt = NODE_UNKNOWN;
      if (net_state < NET_LOCK_MIN && n.node_kind != KIND_NONE) begin
         case (n.node_kind)
            KIND_POWER: begin
               held_tag = n.node_tag;
               nt = NODE_POWER;
               if (!label_seen) begin
                  label_seen  = 1'b1;
                  first_label = n.power_label;
               end else if (first_label != n.power_label) begin
                  // label clash locks the net, no table step
                  net_state = NET_ERR_BASE + ERR_POWER_CLASH;
               end
            end
            KIND_MARKER: begin
               nt = NODE_PASSIVE;
               held_tag = n.node_tag;
               if (links != LINK_MAX) links++;
            end
            KIND_PIN: begin
               held_tag = n.node_tag;
               if (links != LINK_MAX) links++;
               if (n.pin_is_power) begin
                  nt = NODE_POWER;
               end else begin
                  case (n.pin_elec)
                     ELEC_IN:      nt = NODE_INPUT;
                     ELEC_OUT:     nt = NODE_OUTPUT;
                     ELEC_TRI:     nt = NODE_BIDIR;
                     ELEC_OC:      nt = NODE_BIDIR;
                     ELEC_PASSIVE: nt = NODE_PASSIVE;
                     ELEC_BIDIR:   nt = NODE_BIDIR;
                     ELEC_NC:      nt = NODE_NOCONNECT;
                     default:      nt = NODE_UNKNOWN;
                  endcase
               end
            end
            default: begin
               // other objects and kinds past the pin: no type, no link, no tag
               nt = NODE_UNKNOWN;
            end
         endcase
         if (net_state < NET_LOCK_MIN) net_state = next_net(net_state, nt);
      end
      if (n.last_of_net) begin
         verdict = net_state;
         // a lone connection wins over everything but a noconnect net
         if (links == 2'd1 && verdict != NET_NOCONNECT) verdict = NET_ERR_BASE + ERR_SINGLE_LINK;
         if (verdict >= NET_LOCK_MIN) begin
            code = err_code_type'(verdict - NET_ERR_BASE);
         end else if (verdict == NET_UNKNOWN) begin
            code = (links != 2'd0) ? ERR_STRAY : ERR_NONE;
         end else if (verdict == NET_INPUT) begin
            code = ERR_NO_DRIVER;
         end else begin
            code = ERR_NONE;
         end
         case (code)
            ERR_SINGLE_LINK:                on = enable_bits[0];
            ERR_POWER_CLASH:                on = enable_bits[1];
            ERR_NC_CONFLICT:                on = enable_bits[2];
            ERR_NO_DRIVER:                  on = enable_bits[3];
            ERR_OUTPUTS, ERR_OUT_BIDIR:     on = enable_bits[4];
            ERR_OUT_POWER, ERR_POWER_BIDIR: on = enable_bits[5];
            ERR_STRAY:                      on = enable_bits[6];
            default:                        on = 1'b0;
         endcase
         if (!on) code = ERR_NONE;
         r.error_code  = code;
         r.locator_tag = held_tag;
         net_results = {net_results, r};
         net_state   = NET_UNKNOWN;
         links       = 2'd0;
         label_seen  = 1'b0;
         first_label = '0;
         held_tag    = '0;
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int idle_cycles(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   function automatic req_type make_node(input logic [2:0] kind, input logic [2:0] elec,
                                         input logic pwr, input logic [LABEL_BITS-1:0] label,
                                         input logic [TAG_BITS-1:0] tag, input logic last);
      req_type n;
      n.node_kind    = kind;
      n.pin_elec     = elec;
      n.pin_is_power = pwr;
      n.power_label  = label;
      n.node_tag     = tag;
      n.last_of_net  = last;
      return n;
   endfunction

   // offer one request, entered and left at a falling edge
   task automatic send_node(input req_type n);
      int gap;
      gap = idle_cycles(req_idle_pct);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = n;
      do @(posedge clock); while (!req_ready);
      classify_node(n);
      if (n.node_kind != KIND_NONE) nodes_sent++;
      @(negedge clock);
   endtask

   // one net of random nodes, power labels mostly agreeing
   task automatic send_random_net(input int max_nodes);
      int                    count;
      int                    pick;
      logic [LABEL_BITS-1:0] base_label;
      req_type               n;
      count = $urandom_range(max_nodes, 1);
      base_label = LABEL_BITS'($urandom);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) n.node_kind = KIND_PIN;
         else if (pick < 70) n.node_kind = KIND_POWER;
         else if (pick < 80) n.node_kind = KIND_MARKER;
         else if (pick < 88) n.node_kind = KIND_OTHER;
         else if (pick < 94) n.node_kind = KIND_NONE;
         else n.node_kind = 3'($urandom_range(7, 5));
         n.pin_elec     = 3'($urandom_range(7));
         n.pin_is_power = ($urandom_range(7) == 0);
         n.power_label  = ($urandom_range(3) == 0) ? LABEL_BITS'($urandom) : base_label;
         n.node_tag     = TAG_BITS'($urandom);
         // a stray end mark now and then splits the net early
         n.last_of_net  = (i == count - 1) || ($urandom_range(49) == 0);
         send_node(n);
      end
   endtask

   // register write only with no net in flight
   task automatic write_enable(input logic [ENABLE_BITS-1:0] value);
      req_valid = 1'b0;
      while (net_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      enable_bits = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one net per rule, with field extremes, under the reset enable value
   task automatic test_directed_nets();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      // ignored node alone: clean empty net
      send_node(make_node(KIND_NONE, ELEC_IN, 1'b0, 16'h0000, 16'hffff, 1'b1));
      // other object does not move the tag
      send_node(make_node(KIND_OTHER, ELEC_UNDEF, 1'b1, 16'hffff, 16'hffff, 1'b1));
      // lone not-connected pin is fine
      send_node(make_node(KIND_PIN, ELEC_NC, 1'b0, 16'h0000, 16'hffff, 1'b1));
      // lone input pin: single connection
      send_node(make_node(KIND_PIN, ELEC_IN, 1'b0, 16'hffff, 16'h0000, 1'b1));
      // power label clash
      send_node(make_node(KIND_POWER, ELEC_IN, 1'b0, 16'h0000, 16'h0101, 1'b0));
      send_node(make_node(KIND_POWER, ELEC_IN, 1'b0, 16'hffff, 16'h0102, 1'b1));
      // powered net with loads
      send_node(make_node(KIND_POWER, ELEC_OUT, 1'b0, 16'hffff, 16'h0201, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_IN, 1'b0, 16'h1234, 16'h0202, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_PASSIVE, 1'b0, 16'h0000, 16'h0203, 1'b1));
      // inputs only: no driver
      send_node(make_node(KIND_PIN, ELEC_IN, 1'b0, 16'h0000, 16'h0301, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_IN, 1'b0, 16'h0000, 16'h0302, 1'b1));
      // output against tristate
      send_node(make_node(KIND_PIN, ELEC_OUT, 1'b0, 16'h0000, 16'h0401, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_TRI, 1'b0, 16'h0000, 16'h0402, 1'b1));
      // open collector against a power pin
      send_node(make_node(KIND_PIN, ELEC_OC, 1'b0, 16'h0000, 16'h0501, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_OUT, 1'b1, 16'h0000, 16'h0502, 1'b1));
      // output driving a power net
      send_node(make_node(KIND_POWER, ELEC_IN, 1'b0, 16'h00aa, 16'h0601, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_OUT, 1'b0, 16'h0000, 16'h0602, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_BIDIR, 1'b0, 16'h0000, 16'h0603, 1'b1));
      // untyped pins only: stray
      send_node(make_node(KIND_PIN, ELEC_UNDEF, 1'b0, 16'h0000, 16'h0701, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_UNDEF, 1'b0, 16'h0000, 16'h0702, 1'b1));
      // locked on two outputs, later nodes leave tag and type alone
      send_node(make_node(KIND_PIN, ELEC_OUT, 1'b0, 16'h0000, 16'h0801, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_OUT, 1'b0, 16'h0000, 16'h0802, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_NC, 1'b0, 16'h0000, 16'h0803, 1'b1));
      // single connection overrides a power clash lock
      send_node(make_node(KIND_PIN, ELEC_IN, 1'b0, 16'h0000, 16'h0901, 1'b0));
      send_node(make_node(KIND_POWER, ELEC_IN, 1'b0, 16'h0011, 16'h0902, 1'b0));
      send_node(make_node(KIND_POWER, ELEC_IN, 1'b0, 16'h0022, 16'h0903, 1'b1));
      // marker plus not-connected pin
      send_node(make_node(KIND_MARKER, ELEC_IN, 1'b0, 16'h0000, 16'h0a01, 1'b0));
      send_node(make_node(KIND_PIN, ELEC_NC, 1'b0, 16'h0000, 16'h0a02, 1'b1));
   endtask

   // random nets, first back to back, then with idling on both sides
   task automatic test_random_nets(input int target);
      int start;
      start = nodes_sent;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (nodes_sent - start < target / 3) send_random_net(6);
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      while (nodes_sent - start < target) send_random_net(6);
   endtask

   // several enable settings, both extremes among them
   task automatic test_enable_settings(input int per_setting);
      int start;
      logic [ENABLE_BITS-1:0] value;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      for (int s = 0; s < 6; s++) begin
         case (s)
            0:       value = ENABLE_NONE;
            1:       value = 7'h55;
            2:       value = 7'h2a;
            3:       value = ENABLE_ALL;
            default: value = ENABLE_BITS'($urandom);
         endcase
         write_enable(value);
         start = nodes_sent;
         while (nodes_sent - start < per_setting) send_random_net(5);
      end
   endtask

   // receiver holds off for a long time while requests keep coming
   task automatic test_backpressure(input int target);
      int start;
      req_idle_pct = 0;
      rsp_idle_pct = 10;
      rsp_hold_req = 200;
      start = nodes_sent;
      while (nodes_sent - start < target) send_random_net(3);
   endtask

   // response side: ready with random stalls, long hold when asked
   initial begin
      int wait_left;
      wait_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req != 0) begin
            wait_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (wait_left != 0) begin
            rsp_ready = 1'b0;
            wait_left--;
         end else begin
            rsp_ready = 1'b1;
            wait_left = idle_cycles(rsp_idle_pct);
         end
      end
   end

   // compare each accepted response with the oldest pending net verdict
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (net_results.size() == 0) begin
               $error("response with no net pending: error_code %0d locator_tag %h",
                      rsp_data.error_code, rsp_data.locator_tag);
               fail_count++;
            end else begin
               want = net_results.pop_front();
               if (rsp_data.error_code !== want.error_code) begin
                  $error("error_code: expected %0d, got %0d",
                         want.error_code, rsp_data.error_code);
                  fail_count++;
               end
               if (rsp_data.locator_tag !== want.locator_tag) begin
                  $error("locator_tag: expected %h, got %h",
                         want.locator_tag, rsp_data.locator_tag);
                  fail_count++;
               end
            end
         end
      end
   end

   // hard stop in case the block hangs
   initial begin
      #(8 * LIMIT_CYCLES);
      $display("net_electrical_rule_classifier_core test failed");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_directed_nets();
      test_random_nets(800);
      test_enable_settings(50);
      test_backpressure(150);

      // drain, then let any late extra response show up
      req_valid = 1'b0;
      while (net_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("net_electrical_rule_classifier_core test passed");
      end else begin
         $display("net_electrical_rule_classifier_core test failed");
      end
      $finish;
   end

endmodule
